[rtl/wavh_pkg.sv]
// shared types, codes and tables of the wav header checker
// used by the front parser, the command queue, the back emitter and the top level
package wavh_pkg;

   localparam int HEADER_BYTES = 44;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // result status codes
   localparam logic [3:0] ST_BYTE  = 4'd0;
   localparam logic [3:0] ST_OK    = 4'd1;
   localparam logic [3:0] ST_RIFF  = 4'd2;
   localparam logic [3:0] ST_WAVE  = 4'd3;
   localparam logic [3:0] ST_FMT   = 4'd4;
   localparam logic [3:0] ST_CHUNK = 4'd5;
   localparam logic [3:0] ST_TYPE  = 4'd6;
   localparam logic [3:0] ST_CHANS = 4'd7;
   localparam logic [3:0] ST_RATE  = 4'd8;
   localparam logic [3:0] ST_BITS  = 4'd9;
   localparam logic [3:0] ST_ALIGN = 4'd10;
   localparam logic [3:0] ST_DATA  = 4'd11;
   localparam logic [3:0] ST_SHORT = 4'd12;
   localparam logic [3:0] ST_SIZE  = 4'd13;
   localparam logic [3:0] ST_TRUNC = 4'd14;

   // mode register codes
   localparam logic [2:0] MODE_CHECK  = 3'd1;
   localparam logic [2:0] MODE_HALVE  = 3'd2;
   localparam logic [2:0] MODE_DOUBLE = 3'd3;
   localparam logic [2:0] MODE_LEFT   = 3'd4;
   localparam logic [2:0] MODE_RIGHT  = 3'd5;
   localparam logic [2:0] MODE_VOLUME = 3'd6;

   // register index of the mode register
   localparam logic [1:0] REG_MODE = 2'd0;

   // tags, first character in the lowest byte
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WORD,
      OP_MONO
   } op_type;

   // one command per item: bytes of a word or a mono header, then an optional status
   typedef struct packed {
      op_type      op;
      logic [2:0]  count;
      logic [31:0] word;
      logic        has_status;
      logic [3:0]  status;
   } cmd_type;

   // rewritten mono header values
   typedef struct packed {
      logic [31:0] riff_size;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits;
      logic [31:0] data_size;
   } mono_type;

   // expected tag byte at a header position, zero where no tag lies
   function automatic logic [7:0] tag_byte(input logic [5:0] p);
      logic [7:0] t;
      t = 8'h00;
      case (p)
         6'd0:  t = TAG_RIFF[7:0];
         6'd1:  t = TAG_RIFF[15:8];
         6'd2:  t = TAG_RIFF[23:16];
         6'd3:  t = TAG_RIFF[31:24];
         6'd8:  t = TAG_WAVE[7:0];
         6'd9:  t = TAG_WAVE[15:8];
         6'd10: t = TAG_WAVE[23:16];
         6'd11: t = TAG_WAVE[31:24];
         6'd12: t = TAG_FMT[7:0];
         6'd13: t = TAG_FMT[15:8];
         6'd14: t = TAG_FMT[23:16];
         6'd15: t = TAG_FMT[31:24];
         6'd36: t = TAG_DATA[7:0];
         6'd37: t = TAG_DATA[15:8];
         6'd38: t = TAG_DATA[23:16];
         6'd39: t = TAG_DATA[31:24];
         default: t = 8'h00;
      endcase
      return t;
   endfunction

   // byte i of the rewritten mono header
   function automatic logic [7:0] mono_byte(input mono_type h, input logic [5:0] i);
      logic [351:0] hdr;
      hdr = {h.data_size, TAG_DATA, h.bits, h.block_align, h.byte_rate, h.sample_rate,
             16'd1, 16'd1, 32'd16, TAG_FMT, TAG_WAVE, h.riff_size, TAG_RIFF};
      return hdr[{i, 3'b000} +: 8];
   endfunction

endpackage

[rtl/wavh_front.sv]
// front part: accepts items, parses and checks the header, tracks the data part
// and issues one command per item; uses wavh_pkg
module wavh_front import wavh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       kind,
   input  logic [7:0] in_byte,
   input  logic [2:0] mode,
   input  logic       mono_done,
   output logic       hold,
   output logic       push,
   output cmd_type    cmd,
   output mono_type   snap
);

   logic [5:0]  pos_ff, pos_in;
   logic [31:0] fa_ff, fa_in;
   logic [31:0] fsize_ff, fsize_in;
   logic [31:0] srate_ff, srate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;
   logic [1:0]  chan_ff, chan_in;
   logic [31:0] dsize_ff, dsize_in;
   logic [31:0] dcount_ff, dcount_in;
   logic [15:0] fbi_ff, fbi_in;
   logic [15:0] sacc_ff, sacc_in;
   logic        failed_ff, failed_in;
   logic        mono_busy_ff, mono_busy_in;
   mono_type    snap_ff, snap_in;

   logic [2:0]         m;
   logic               rate_m, chan_m, stereo, clear;
   logic [31:0]        fa_new;
   logic [15:0]        v;
   logic [7:0]         tag;
   logic [3:0]         err;
   logic [47:0]        prod;
   logic [16:0]        align_chk;
   logic [15:0]        nacc;
   logic [16:0]        fbi1, nb;
   logic signed [16:0] sx;
   logic [16:0]        sh;
   logic               first;

   // parse and classify one item
   always_comb begin
      pos_in       = pos_ff;
      fa_in        = fa_ff;
      fsize_in     = fsize_ff;
      srate_in     = srate_ff;
      brate_in     = brate_ff;
      align_in     = align_ff;
      bits_in      = bits_ff;
      chan_in      = chan_ff;
      dsize_in     = dsize_ff;
      dcount_in    = dcount_ff;
      fbi_in       = fbi_ff;
      sacc_in      = sacc_ff;
      failed_in    = failed_ff;
      mono_busy_in = mono_busy_ff;
      snap_in      = snap_ff;
      cmd          = '0;
      push         = 1'b0;
      clear        = 1'b0;
      err          = ST_BYTE;

      m      = (mode >= MODE_CHECK && mode <= MODE_VOLUME) ? mode : MODE_CHECK;
      rate_m = (m == MODE_HALVE) || (m == MODE_DOUBLE);
      chan_m = (m == MODE_LEFT) || (m == MODE_RIGHT);
      stereo = chan_m && (chan_ff == 2'd2);

      fa_new    = {in_byte, fa_ff[31:8]};
      v         = fa_new[31:16];
      tag       = tag_byte(pos_ff);
      prod      = srate_ff * v;
      align_chk = {4'b0, v[15:3]} * {15'b0, chan_ff};
      nacc      = (fbi_ff == 16'd0) ? {8'b0, in_byte} : {sacc_ff[15:8] | in_byte, sacc_ff[7:0]};
      fbi1      = {1'b0, fbi_ff} + 17'd1;
      nb        = (bits_ff == 16'd16) ? 17'd2 : 17'd1;
      sx        = $signed({nacc[15], nacc}) + (nacc[15] ? 17'sd7 : 17'sd0);
      sh        = 17'(sx >>> 3);
      first     = fbi_ff < {1'b0, align_ff[15:1]};

      if (accept) begin
         if (kind) begin
            // end of file: report, or rearm silently after a failure
            clear = 1'b1;
            if (!failed_ff) begin
               cmd.has_status = 1'b1;
               if (pos_ff < 6'(HEADER_BYTES)) begin
                  cmd.status = ST_TRUNC;
               end else if (stereo) begin
                  if ({1'b0, dsize_ff} > {dcount_ff, 1'b0}) begin
                     cmd.status = ST_SHORT;
                  end else if (dcount_ff != fsize_ff - 32'd36 - {1'b0, dsize_ff[31:1]}) begin
                     cmd.status = ST_SIZE;
                  end else begin
                     cmd.status = ST_OK;
                  end
               end else begin
                  if (dsize_ff > dcount_ff) begin
                     cmd.status = ST_SHORT;
                  end else if (dcount_ff != fsize_ff - 32'd36) begin
                     cmd.status = ST_SIZE;
                  end else begin
                     cmd.status = ST_OK;
                  end
               end
            end
         end else if (!failed_ff) begin
            if (pos_ff < 6'(HEADER_BYTES)) begin
               // header byte
               fa_in  = fa_new;
               pos_in = pos_ff + 6'd1;
               if (m == MODE_VOLUME || (rate_m && (pos_ff < 6'd24 || pos_ff > 6'd31))) begin
                  cmd.op    = OP_WORD;
                  cmd.count = 3'd1;
                  cmd.word  = {24'b0, in_byte};
               end
               if (tag != 8'h00 && in_byte != tag) begin
                  err = (pos_ff < 6'd4) ? ST_RIFF : (pos_ff < 6'd12) ? ST_WAVE :
                        (pos_ff < 6'd16) ? ST_FMT : ST_DATA;
               end else begin
                  case (pos_ff)
                     6'd7: fsize_in = fa_new;
                     6'd19: begin
                        if (fa_new != 32'd16) err = ST_CHUNK;
                     end
                     6'd21: begin
                        if (v != 16'd1) err = ST_TYPE;
                     end
                     6'd23: begin
                        if (v != 16'd1 && v != 16'd2) err = ST_CHANS;
                        else chan_in = v[1:0];
                     end
                     6'd27, 6'd31: begin
                        if (pos_ff == 6'd27) srate_in = fa_new;
                        else brate_in = fa_new;
                        if (rate_m) begin
                           cmd.op    = OP_WORD;
                           cmd.count = 3'd4;
                           cmd.word  = (m == MODE_HALVE) ? {1'b0, fa_new[31:1]}
                                                         : {fa_new[30:0], 1'b0};
                        end
                     end
                     6'd33: begin
                        align_in = v;
                        if (brate_ff != prod[31:0]) err = ST_RATE;
                     end
                     6'd35: begin
                        bits_in = v;
                        if (v != 16'd8 && v != 16'd16) err = ST_BITS;
                        else if ({1'b0, align_ff} != align_chk) err = ST_ALIGN;
                     end
                     6'd43: begin
                        dsize_in = fa_new;
                        if (chan_m) begin
                           cmd.op              = OP_MONO;
                           snap_in.sample_rate = srate_ff;
                           snap_in.bits        = bits_ff;
                           if (chan_ff == 2'd2) begin
                              snap_in.riff_size   = fsize_ff - {1'b0, fa_new[31:1]};
                              snap_in.byte_rate   = {1'b0, brate_ff[31:1]};
                              snap_in.block_align = {1'b0, align_ff[15:1]};
                              snap_in.data_size   = {1'b0, fa_new[31:1]};
                           end else begin
                              snap_in.riff_size   = fsize_ff;
                              snap_in.byte_rate   = brate_ff;
                              snap_in.block_align = align_ff;
                              snap_in.data_size   = fa_new;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
               if (err != ST_BYTE) begin
                  cmd.has_status = 1'b1;
                  cmd.status     = err;
                  failed_in      = 1'b1;
               end
            end else if (m == MODE_VOLUME) begin
               // data byte, volume divide
               dcount_in = dcount_ff + 32'd1;
               if (fbi_ff != 16'd0 || dcount_ff < dsize_ff) begin
                  sacc_in = nacc;
                  if (fbi1 >= nb) begin
                     fbi_in = 16'd0;
                     cmd.op = OP_WORD;
                     if (nb == 17'd1) begin
                        cmd.count = 3'd1;
                        cmd.word  = {27'b0, nacc[7:3]};
                     end else begin
                        cmd.count = 3'd2;
                        cmd.word  = {16'b0, sh[15:0]};
                     end
                  end else begin
                     fbi_in = 16'd1;
                  end
               end else begin
                  cmd.op    = OP_WORD;
                  cmd.count = 3'd1;
                  cmd.word  = {24'b0, in_byte};
               end
            end else if (stereo) begin
               // data byte, channel extraction
               if (fbi_ff != 16'd0 || {dcount_ff, 1'b0} < {1'b0, dsize_ff}) begin
                  if ((m == MODE_LEFT) == first) begin
                     cmd.op    = OP_WORD;
                     cmd.count = 3'd1;
                     cmd.word  = {24'b0, in_byte};
                     dcount_in = dcount_ff + 32'd1;
                  end
                  fbi_in = (fbi1 >= {1'b0, align_ff}) ? 16'd0 : fbi1[15:0];
               end else begin
                  cmd.op    = OP_WORD;
                  cmd.count = 3'd1;
                  cmd.word  = {24'b0, in_byte};
                  dcount_in = dcount_ff + 32'd1;
               end
            end else begin
               // data byte, plain echo or count only
               if (m != MODE_CHECK) begin
                  cmd.op    = OP_WORD;
                  cmd.count = 3'd1;
                  cmd.word  = {24'b0, in_byte};
               end
               dcount_in = dcount_ff + 32'd1;
            end
         end
         push = (cmd.op != OP_NONE) || cmd.has_status;
      end

      // a mono header is outstanding until the back part has sent its last byte
      if (mono_done) mono_busy_in = 1'b0;
      if (push && cmd.op == OP_MONO) mono_busy_in = 1'b1;

      // rearm for the next file
      if (clear) begin
         pos_in    = '0;
         fa_in     = '0;
         fsize_in  = '0;
         srate_in  = '0;
         brate_in  = '0;
         align_in  = '0;
         bits_in   = '0;
         chan_in   = '0;
         dsize_in  = '0;
         dcount_in = '0;
         fbi_in    = '0;
         sacc_in   = '0;
         failed_in = 1'b0;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         fa_ff        <= '0;
         fsize_ff     <= '0;
         srate_ff     <= '0;
         brate_ff     <= '0;
         align_ff     <= '0;
         bits_ff      <= '0;
         chan_ff      <= '0;
         dsize_ff     <= '0;
         dcount_ff    <= '0;
         fbi_ff       <= '0;
         sacc_ff      <= '0;
         failed_ff    <= 1'b0;
         mono_busy_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         fa_ff        <= fa_in;
         fsize_ff     <= fsize_in;
         srate_ff     <= srate_in;
         brate_ff     <= brate_in;
         align_ff     <= align_in;
         bits_ff      <= bits_in;
         chan_ff      <= chan_in;
         dsize_ff     <= dsize_in;
         dcount_ff    <= dcount_in;
         fbi_ff       <= fbi_in;
         sacc_ff      <= sacc_in;
         failed_ff    <= failed_in;
         mono_busy_ff <= mono_busy_in;
      end
   end

   // mono header snapshot, held while the back part emits it
   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign snap = snap_ff;

   // the last header byte waits while the snapshot is still in use
   assign hold = mono_busy_ff && (pos_ff == 6'd43);

endmodule

[rtl/wavh_queue.sv]
// short command queue between the front parser and the back emitter
// uses wavh_pkg for the command type and depth
module wavh_queue import wavh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cmd_type           push_data,
   input  logic              pop,
   output logic              pop_valid,
   output cmd_type           pop_data,
   output logic              full,
   output logic [QCNT_W-1:0] count
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = entry_ff[rd_ff];
   assign count     = cnt_ff;

   // pointer and fill bookkeeping
   always_comb begin
      do_push = push && !full;
      do_pop  = pop && pop_valid;
      wr_in   = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in   = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in  = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= push_data;
   end

endmodule

[rtl/wavh_back.sv]
// back part: expands queued commands into result items through an output register
// uses wavh_pkg for the command and header types
module wavh_back import wavh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  cmd_type    q_data,
   output logic       q_pop,
   input  mono_type   snap,
   output logic       mono_done,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic [3:0] out_status,
   output logic       out_last
);

   cmd_type    cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [5:0] idx_ff, idx_in;
   logic       ov_ff, ov_in;
   logic [7:0] ob_ff, ob_in;
   logic [3:0] os_ff, os_in;
   logic       ol_ff, ol_in;

   logic [5:0] nbytes, total;
   logic       advance, final_item;
   logic [7:0] sel_byte;

   // step through the current command
   always_comb begin
      case (cur_ff.op)
         OP_WORD: nbytes = {3'b0, cur_ff.count};
         OP_MONO: nbytes = 6'(HEADER_BYTES);
         default: nbytes = 6'd0;
      endcase
      total      = nbytes + {5'b0, cur_ff.has_status};
      final_item = (idx_ff + 6'd1 == total);
      advance    = cur_valid_ff && (!ov_ff || out_ready);
      sel_byte   = (cur_ff.op == OP_MONO) ? mono_byte(snap, idx_ff)
                                          : cur_ff.word[{idx_ff[1:0], 3'b000} +: 8];
      q_pop      = q_valid && (!cur_valid_ff || (advance && final_item));
      mono_done  = advance && final_item && (cur_ff.op == OP_MONO);

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      ov_in        = ov_ff && !out_ready;
      ob_in        = ob_ff;
      os_in        = os_ff;
      ol_in        = ol_ff;

      if (advance) begin
         ov_in = 1'b1;
         ol_in = final_item;
         if (idx_ff < nbytes) begin
            ob_in = sel_byte;
            os_in = ST_BYTE;
         end else begin
            ob_in = 8'h00;
            os_in = cur_ff.status;
         end
         idx_in = final_item ? 6'd0 : idx_ff + 6'd1;
         if (final_item) cur_valid_in = 1'b0;
      end
      if (q_pop) begin
         cur_in       = q_data;
         cur_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         ov_ff        <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         ov_ff        <= ov_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      ob_ff  <= ob_in;
      os_ff  <= os_in;
      ol_ff  <= ol_in;
   end

   assign out_valid  = ov_ff;
   assign out_byte   = ob_ff;
   assign out_status = os_ff;
   assign out_last   = ol_ff;

endmodule

[rtl/wav_header_check_and_transform.sv]
// top level of the wav header checker and transformer
// holds the mode register and joins wavh_front, wavh_queue and wavh_back; uses wavh_pkg
//
// A byte stream carrying a 44-byte canonical PCM WAV file, closed by an end item
// (req_tuser high), is checked field by field and reported with one status item per file;
// by the mode register the file is also echoed with rates halved or doubled, reduced to
// one channel under a rewritten mono header, or echoed with samples divided by 8. Input
// items are taken one per cycle while the four-entry command queue has room; each item's
// results leave one per cycle from the output register while rsp_tready is high, the
// longest bursts being the 44-byte mono header and the 4-byte rate field. The last
// header byte of a file also waits while the mono header of an earlier file is still
// being sent. The mode register is to be written only while the block is idle; the
// block itself does not enforce this.
module wav_header_check_and_transform import wavh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte[7:0], status[11:8], zero[15:12]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [2:0]        mode_ff, mode_in;
   logic              accept, push, full, q_valid, q_pop, hold, mono_done;
   cmd_type           cmd, q_data;
   mono_type          snap;
   logic [QCNT_W-1:0] q_count;
   logic [7:0]        out_byte;
   logic [3:0]        out_status;

   // mode register
   assign csr_pready = 1'b1;
   assign csr_prdata = {29'b0, mode_ff};
   always_comb begin
      mode_in = mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_MODE)
         mode_in = csr_pwdata[2:0];
   end
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_CHECK;
      else       mode_ff <= mode_in;
   end

   assign req_tready = !full && !hold;
   assign accept     = req_tvalid && req_tready;

   wavh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_tuser),
      .in_byte   (req_tdata),
      .mode      (mode_ff),
      .mono_done (mono_done),
      .hold      (hold),
      .push      (push),
      .cmd       (cmd),
      .snap      (snap)
   );

   wavh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data),
      .full      (full),
      .count     (q_count)
   );

   wavh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .snap       (snap),
      .mono_done  (mono_done),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (out_byte),
      .out_status (out_status),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {4'b0, out_status, out_byte};

   // queue never overfills and stalls the input when full
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QUEUE_DEPTH)) else $error("command queue overfilled");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      (q_count == QCNT_W'(QUEUE_DEPTH)) |-> !req_tready) else $error("input taken while full");

   // a status item carries a zero byte and closes its item's results
   a_status_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_status != ST_BYTE) |-> (out_byte == 8'h00 && rsp_tlast))
      else $error("malformed status item");

endmodule
